FILE: src/qoig_pkg.sv
// ----------------------------------------------------------------------------
// qoig_pkg: shared types and microcode for the quadtree order index generator
// holds the register map, the sequencer step codes and the control store
// ----------------------------------------------------------------------------
package qoig_pkg;

	// register map, byte addresses
	localparam int unsigned PADDR_W = 4;
	localparam logic [PADDR_W-1:0] ADDR_SIDE_X     = 4'h0;
	localparam logic [PADDR_W-1:0] ADDR_SIDE_Y     = 4'h4;
	localparam logic [PADDR_W-1:0] ADDR_ROW_STRIDE = 4'h8;

	// register widths and reset values
	localparam int unsigned SIDE_W   = 6;
	localparam int unsigned STRIDE_W = 7;
	localparam logic [SIDE_W-1:0]   SIDE_RESET   = 6'd28;
	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 7'd28;

	// result field widths
	localparam int unsigned INDEX_W = 11;
	localparam int unsigned COORD_W = 5;
	localparam int unsigned POS_W   = 10;

	// sequencer steps
	typedef enum logic [2:0] {
		STEP_IDLE,
		STEP_TOTAL,
		STEP_Q0,
		STEP_Q1,
		STEP_Q2,
		STEP_EMIT
	} step_t;

	// multiplier operand selects
	typedef enum logic [1:0] {
		A_LX,
		A_LW,
		A_RW,
		A_STRIDE
	} mul_a_t;

	typedef enum logic [1:0] {
		B_LY,
		B_TH,
		B_BH,
		B_X
	} mul_b_t;

	// datapath operations
	typedef enum logic [2:0] {
		OP_LOAD,
		OP_TOTAL,
		OP_Q0,
		OP_Q1,
		OP_Q2,
		OP_EMIT
	} dp_op_t;

	// branch conditions
	typedef enum logic [1:0] {
		COND_NO_IN,
		COND_ALWAYS,
		COND_HIT,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		mul_a_t a_sel;
		mul_b_t b_sel;
		dp_op_t op;
		cond_t  cond;
		logic   exit_done;
		step_t  jt;
		step_t  jf;
	} ctrl_word_t;

	// exit target when the descent is finished
	localparam step_t STEP_EXIT = STEP_EMIT;

	// control store
	function automatic ctrl_word_t ucode(input step_t s);
		ctrl_word_t w;
		w = '{a_sel: A_LX, b_sel: B_LY, op: OP_LOAD, cond: COND_NO_IN,
			exit_done: 1'b0, jt: STEP_IDLE, jf: STEP_TOTAL};
		unique case (s)
			STEP_IDLE: begin
				w = '{a_sel: A_LX, b_sel: B_LY, op: OP_LOAD, cond: COND_NO_IN,
					exit_done: 1'b0, jt: STEP_IDLE, jf: STEP_TOTAL};
			end
			STEP_TOTAL: begin
				w = '{a_sel: A_LX, b_sel: B_LY, op: OP_TOTAL, cond: COND_ALWAYS,
					exit_done: 1'b0, jt: STEP_Q0, jf: STEP_Q0};
			end
			STEP_Q0: begin
				w = '{a_sel: A_LW, b_sel: B_TH, op: OP_Q0, cond: COND_HIT,
					exit_done: 1'b1, jt: STEP_Q0, jf: STEP_Q1};
			end
			STEP_Q1: begin
				w = '{a_sel: A_RW, b_sel: B_TH, op: OP_Q1, cond: COND_HIT,
					exit_done: 1'b0, jt: STEP_Q0, jf: STEP_Q2};
			end
			STEP_Q2: begin
				w = '{a_sel: A_LW, b_sel: B_BH, op: OP_Q2, cond: COND_ALWAYS,
					exit_done: 1'b0, jt: STEP_Q0, jf: STEP_Q0};
			end
			STEP_EMIT: begin
				w = '{a_sel: A_STRIDE, b_sel: B_X, op: OP_EMIT, cond: COND_OUT_BUSY,
					exit_done: 1'b0, jt: STEP_EMIT, jf: STEP_IDLE};
			end
			default: begin
				w = '{a_sel: A_LX, b_sel: B_LY, op: OP_LOAD, cond: COND_NO_IN,
					exit_done: 1'b0, jt: STEP_IDLE, jf: STEP_IDLE};
			end
		endcase
		return w;
	endfunction

endpackage

FILE: src/qoig_if.sv
// ----------------------------------------------------------------------------
// qoig channel interfaces
// request channel carries the restart flag, response channel one cell
// ----------------------------------------------------------------------------
interface qoig_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

interface qoig_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [qoig_pkg::INDEX_W-1:0] index;
	logic [qoig_pkg::COORD_W-1:0] coord_x;
	logic [qoig_pkg::COORD_W-1:0] coord_y;
	logic [qoig_pkg::POS_W-1:0]   position;
	logic                         last;

	modport source (output valid, output index, output coord_x, output coord_y,
		output position, output last, input ready);
	modport sink   (input valid, input index, input coord_x, input coord_y,
		input position, input last, output ready);
endinterface

FILE: src/quadtree_order_index_generator_core.sv
// ----------------------------------------------------------------------------
// quadtree order index generator core
// emits the cells of a side_x by side_y grid in recursive quadtree order
// ----------------------------------------------------------------------------
// Each request transaction yields one response transaction: the next cell of
// the quadtree traversal with its linear index (row_stride * x + y), its
// coordinates, its order position and a last flag; restart=1 begins again at
// position 0, and after the last cell the traversal wraps to position 0. The
// cell is found by descending from the root through a microcoded sequencer
// driving one shared multiplier: after the idle step that accepts a request,
// the sequencer computes the cell count, descends L levels (L at most
// STACK_DEPTH) at one multiplier step per quadrant tested and one to three
// quadrants per level, makes a final leaf test and then emits the result into
// the result register. Requests are taken one at a time; a finished result
// waits in the output register while the next request is accepted, and the
// emit step holds for as long as an earlier result is still waiting unread.
// Configuration is written through the APB port; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module quadtree_order_index_generator_core #(
	parameter int unsigned MAX_SIDE    = 32,
	parameter int unsigned STACK_DEPTH = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [qoig_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	// channels
	qoig_req_if.sink                     req,
	qoig_rsp_if.source                   rsp
);

	// side lengths, coordinates, cell counts, multiplier and level widths
	localparam int unsigned SW   = $clog2(MAX_SIDE + 1);
	localparam int unsigned CW   = $clog2(MAX_SIDE);
	localparam int unsigned KW   = 2 * SW;
	localparam int unsigned MW   = (SW > qoig_pkg::STRIDE_W) ? SW : qoig_pkg::STRIDE_W;
	localparam int unsigned PW   = 2 * MW;
	localparam int unsigned LVW  = $clog2(STACK_DEPTH + 1);
	localparam int unsigned EXTW = SW + qoig_pkg::SIDE_W;

	// configuration registers
	logic [qoig_pkg::SIDE_W-1:0]   side_x_q;
	logic [qoig_pkg::SIDE_W-1:0]   side_y_q;
	logic [qoig_pkg::STRIDE_W-1:0] row_stride_q;

	// sequencer
	qoig_pkg::step_t      step_q;
	qoig_pkg::step_t      step_d;
	qoig_pkg::ctrl_word_t cw;

	// datapath registers
	logic [SW-1:0]  lx_q;
	logic [SW-1:0]  ly_q;
	logic [CW-1:0]  x_q;
	logic [CW-1:0]  y_q;
	logic [KW-1:0]  k_q;
	logic [KW-1:0]  pos_q;
	logic [KW-1:0]  total_q;
	logic [KW-1:0]  order_count_q;
	logic [LVW-1:0] lvl_q;
	logic           restart_q;

	// output register
	logic                         out_valid_q;
	logic [qoig_pkg::INDEX_W-1:0] out_index_q;
	logic [qoig_pkg::COORD_W-1:0] out_x_q;
	logic [qoig_pkg::COORD_W-1:0] out_y_q;
	logic [qoig_pkg::POS_W-1:0]   out_pos_q;
	logic                         out_last_q;

	// combinational datapath
	logic [SW-1:0]   lx_clamp;
	logic [SW-1:0]   ly_clamp;
	logic [SW:0]     lx_inc;
	logic [SW:0]     ly_inc;
	logic [SW-1:0]   lw;
	logic [SW-1:0]   rw;
	logic [SW-1:0]   th;
	logic [SW-1:0]   bh;
	logic [MW-1:0]   mul_a;
	logic [MW-1:0]   mul_b;
	logic [PW-1:0]   prod;
	logic            hit;
	logic            done;
	logic            out_busy;
	logic            req_fire;
	logic            wrap_zero;
	logic [KW-1:0]   start_k;
	logic            is_last;
	logic [PW-1:0]   index_sum;
	logic [CW+qoig_pkg::COORD_W-1:0] x_ext;
	logic [CW+qoig_pkg::COORD_W-1:0] y_ext;
	logic [KW+qoig_pkg::POS_W-1:0]   pos_ext;
	logic            cfg_wr;

	// --------------------------------------------------------------------
	// configuration port: write on the access cycle, no wait states
	// --------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_x_q     <= qoig_pkg::SIDE_RESET;
			side_y_q     <= qoig_pkg::SIDE_RESET;
			row_stride_q <= qoig_pkg::STRIDE_RESET;
		end else if (cfg_wr) begin
			unique case (paddr)
				qoig_pkg::ADDR_SIDE_X:     side_x_q     <= pwdata[qoig_pkg::SIDE_W-1:0];
				qoig_pkg::ADDR_SIDE_Y:     side_y_q     <= pwdata[qoig_pkg::SIDE_W-1:0];
				qoig_pkg::ADDR_ROW_STRIDE: row_stride_q <= pwdata[qoig_pkg::STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			qoig_pkg::ADDR_SIDE_X:     prdata = 32'(side_x_q);
			qoig_pkg::ADDR_SIDE_Y:     prdata = 32'(side_y_q);
			qoig_pkg::ADDR_ROW_STRIDE: prdata = 32'(row_stride_q);
			default:                   prdata = '0;
		endcase
	end

	// --------------------------------------------------------------------
	// side clamping: zero reads as one, oversized reads as MAX_SIDE
	// --------------------------------------------------------------------
	always_comb begin
		if (side_x_q == '0) begin
			lx_clamp = SW'(1);
		end else if (EXTW'(side_x_q) > EXTW'(MAX_SIDE)) begin
			lx_clamp = SW'(MAX_SIDE);
		end else begin
			lx_clamp = SW'(side_x_q);
		end
		if (side_y_q == '0) begin
			ly_clamp = SW'(1);
		end else if (EXTW'(side_y_q) > EXTW'(MAX_SIDE)) begin
			ly_clamp = SW'(MAX_SIDE);
		end else begin
			ly_clamp = SW'(side_y_q);
		end
	end

	// --------------------------------------------------------------------
	// region split: first part of each side is the rounded-up half
	// --------------------------------------------------------------------
	assign lx_inc = {1'b0, lx_q} + (SW+1)'(1);
	assign ly_inc = {1'b0, ly_q} + (SW+1)'(1);
	assign lw     = lx_inc[SW:1];
	assign th     = ly_inc[SW:1];
	assign rw     = lx_q - lw;
	assign bh     = ly_q - th;

	// leaf reached or stack exhausted
	assign done = ((lx_q == SW'(1)) && (ly_q == SW'(1))) || (lvl_q == LVW'(STACK_DEPTH));

	// --------------------------------------------------------------------
	// shared multiplier with operand selection from the control word
	// --------------------------------------------------------------------
	assign cw = qoig_pkg::ucode(step_q);

	always_comb begin
		case (cw.a_sel)
			qoig_pkg::A_LX:     mul_a = MW'(lx_q);
			qoig_pkg::A_LW:     mul_a = MW'(lw);
			qoig_pkg::A_RW:     mul_a = MW'(rw);
			qoig_pkg::A_STRIDE: mul_a = MW'(row_stride_q);
			default:            mul_a = '0;
		endcase
		case (cw.b_sel)
			qoig_pkg::B_LY: mul_b = MW'(ly_q);
			qoig_pkg::B_TH: mul_b = MW'(th);
			qoig_pkg::B_BH: mul_b = MW'(bh);
			qoig_pkg::B_X:  mul_b = MW'(x_q);
			default:        mul_b = '0;
		endcase
	end

	assign prod = mul_a * mul_b;

	// order position falls inside the quadrant under test
	assign hit = PW'(k_q) < prod;

	// start position: restart, or wrap when the count is past a shrunk grid
	assign wrap_zero = restart_q || (PW'(order_count_q) >= prod);
	assign start_k   = wrap_zero ? '0 : order_count_q;

	assign is_last   = (pos_q == (total_q - KW'(1)));
	assign index_sum = prod + PW'(y_q);
	assign x_ext     = (CW+qoig_pkg::COORD_W)'(x_q);
	assign y_ext     = (CW+qoig_pkg::COORD_W)'(y_q);
	assign pos_ext   = (KW+qoig_pkg::POS_W)'(pos_q);

	// handshake
	assign req.ready = (step_q == qoig_pkg::STEP_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign out_busy  = out_valid_q && !rsp.ready;

	// --------------------------------------------------------------------
	// sequencer: next step from the control word's branch fields
	// --------------------------------------------------------------------
	always_comb begin
		logic take;
		take = 1'b0;
		case (cw.cond)
			qoig_pkg::COND_NO_IN:    take = !req.valid;
			qoig_pkg::COND_ALWAYS:   take = 1'b1;
			qoig_pkg::COND_HIT:      take = hit;
			qoig_pkg::COND_OUT_BUSY: take = out_busy;
			default:                 take = 1'b0;
		endcase
		if (cw.exit_done && done) begin
			step_d = qoig_pkg::STEP_EXIT;
		end else if (take) begin
			step_d = cw.jt;
		end else begin
			step_d = cw.jf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= qoig_pkg::STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// --------------------------------------------------------------------
	// datapath registers without reset
	// --------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (cw.op)
			qoig_pkg::OP_LOAD: begin
				// capture the request and the grid size
				if (req_fire) begin
					restart_q <= req.restart;
					lx_q      <= lx_clamp;
					ly_q      <= ly_clamp;
				end
			end
			qoig_pkg::OP_TOTAL: begin
				// prod holds the cell count here
				total_q <= prod[KW-1:0];
				k_q     <= start_k;
				pos_q   <= start_k;
				x_q     <= '0;
				y_q     <= '0;
				lvl_q   <= '0;
			end
			qoig_pkg::OP_Q0: begin
				// top-left quadrant
				if (!done) begin
					if (hit) begin
						lx_q  <= lw;
						ly_q  <= th;
						lvl_q <= lvl_q + LVW'(1);
					end else begin
						k_q <= k_q - prod[KW-1:0];
					end
				end
			end
			qoig_pkg::OP_Q1: begin
				// top-right quadrant
				if (hit) begin
					x_q   <= x_q + CW'(lw);
					lx_q  <= rw;
					ly_q  <= th;
					lvl_q <= lvl_q + LVW'(1);
				end else begin
					k_q <= k_q - prod[KW-1:0];
				end
			end
			qoig_pkg::OP_Q2: begin
				// bottom-left on a hit, otherwise bottom-right
				if (hit) begin
					y_q  <= y_q + CW'(th);
					lx_q <= lw;
					ly_q <= bh;
				end else begin
					k_q  <= k_q - prod[KW-1:0];
					x_q  <= x_q + CW'(lw);
					y_q  <= y_q + CW'(th);
					lx_q <= rw;
					ly_q <= bh;
				end
				lvl_q <= lvl_q + LVW'(1);
			end
			qoig_pkg::OP_EMIT: begin
				// prod holds row_stride * x here
				if (!out_busy) begin
					out_index_q <= index_sum[qoig_pkg::INDEX_W-1:0];
					out_x_q     <= x_ext[qoig_pkg::COORD_W-1:0];
					out_y_q     <= y_ext[qoig_pkg::COORD_W-1:0];
					out_pos_q   <= pos_ext[qoig_pkg::POS_W-1:0];
					out_last_q  <= is_last;
				end
			end
			default: ;
		endcase
	end

	// --------------------------------------------------------------------
	// control registers: traversal count and output valid
	// --------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_count_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cw.op == qoig_pkg::OP_EMIT && !out_busy) begin
				order_count_q <= is_last ? '0 : pos_q + KW'(1);
				out_valid_q   <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.index    = out_index_q;
	assign rsp.coord_x  = out_x_q;
	assign rsp.coord_y  = out_y_q;
	assign rsp.position = out_pos_q;
	assign rsp.last     = out_last_q;

endmodule

FILE: dv/quadtree_order_index_generator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadtree order index generator core testbench
// drives request transactions with random restart flags over a range of grid
// settings, predicts every cell of the quadtree walk and checks each response
// transaction field by field, with random idling on both channels
// ----------------------------------------------------------------------------
module quadtree_order_index_generator_core_tb;

	localparam int unsigned HALF_PERIOD   = 6;
	localparam int unsigned SIDE_LIMIT    = 32;
	localparam int unsigned STACK_LEVELS  = 6;
	localparam int unsigned ITEM_TARGET   = 1600;
	// leave margin for the worst walk to finish before a register write
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned STALL_LIMIT   = 4000;

	typedef struct packed {
		logic [qoig_pkg::INDEX_W-1:0] index;
		logic [qoig_pkg::COORD_W-1:0] coord_x;
		logic [qoig_pkg::COORD_W-1:0] coord_y;
		logic [qoig_pkg::POS_W-1:0]   position;
		logic                         last;
	} cell_t;

	// predicted walk state and the queue of cells still owed by the block
	class cell_order_book;
		logic [qoig_pkg::SIDE_W-1:0]   side_x;
		logic [qoig_pkg::SIDE_W-1:0]   side_y;
		logic [qoig_pkg::STRIDE_W-1:0] row_stride;
		int unsigned                   next_pos;
		cell_t                         owed_q[$];
		int unsigned                   requests_noted;
		int unsigned                   cells_checked;
		int unsigned                   failures;

		function new();
			side_x         = qoig_pkg::SIDE_RESET;
			side_y         = qoig_pkg::SIDE_RESET;
			row_stride     = qoig_pkg::STRIDE_RESET;
			next_pos       = 0;
			requests_noted = 0;
			cells_checked  = 0;
			failures       = 0;
		endfunction

		function void set_reg(logic [qoig_pkg::PADDR_W-1:0] addr, logic [31:0] data);
			case (addr)
				qoig_pkg::ADDR_SIDE_X: side_x = data[qoig_pkg::SIDE_W-1:0];
				qoig_pkg::ADDR_SIDE_Y: side_y = data[qoig_pkg::SIDE_W-1:0];
				qoig_pkg::ADDR_ROW_STRIDE: row_stride = data[qoig_pkg::STRIDE_W-1:0];
				default: ;
			endcase
		endfunction

		// zero counts as one, anything past the limit is clipped
		function int unsigned usable_side(logic [qoig_pkg::SIDE_W-1:0] v);
			if (v == 0)
				return 1;
			if (v > SIDE_LIMIT)
				return SIDE_LIMIT;
			return v;
		endfunction

		function int unsigned pending();
			return owed_q.size();
		endfunction

		function void note_request(logic restart);
			int unsigned lx, ly, cells, k, cx, cy, lw, rw, th, bh, linear;
			cell_t c;
			lx    = usable_side(side_x);
			ly    = usable_side(side_y);
			cells = lx * ly;
			if (restart || next_pos >= cells)
				next_pos = 0;
			k  = next_pos;
			cx = 0;
			cy = 0;
			// descend: tl, tr, bl, br with the rounded-up half first
			for (int lvl = 0; lvl < STACK_LEVELS && !(lx == 1 && ly == 1); lvl++) begin
				lw = (lx + 1) / 2;
				rw = lx - lw;
				th = (ly + 1) / 2;
				bh = ly - th;
				if (k < lw * th) begin
					lx = lw;
					ly = th;
				end else if (k < lw * th + rw * th) begin
					k  -= lw * th;
					cx += lw;
					lx = rw;
					ly = th;
				end else if (k < lw * th + rw * th + lw * bh) begin
					k  -= lw * th + rw * th;
					cy += th;
					lx = lw;
					ly = bh;
				end else begin
					k  -= lw * th + rw * th + lw * bh;
					cx += lw;
					cy += th;
					lx = rw;
					ly = bh;
				end
			end
			linear     = row_stride * cx + cy;
			c.index    = linear[qoig_pkg::INDEX_W-1:0];
			c.coord_x  = cx[qoig_pkg::COORD_W-1:0];
			c.coord_y  = cy[qoig_pkg::COORD_W-1:0];
			c.position = next_pos[qoig_pkg::POS_W-1:0];
			c.last     = (next_pos == cells - 1);
			next_pos   = c.last ? 0 : next_pos + 1;
			owed_q.push_back(c);
			requests_noted++;
		endfunction

		function void check_cell(cell_t got);
			cell_t want;
			cells_checked++;
			if (owed_q.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected cell idx %0d x %0d y %0d pos %0d last %0d",
						got.index, got.coord_x, got.coord_y, got.position, got.last);
				return;
			end
			want = owed_q.pop_front();
			if (got.index !== want.index || got.coord_x !== want.coord_x ||
					got.coord_y !== want.coord_y || got.position !== want.position ||
					got.last !== want.last) begin
				failures++;
				if (failures <= 10)
					$display("cell mismatch: want idx %0d x %0d y %0d pos %0d last %0d, %s",
						want.index, want.coord_x, want.coord_y, want.position, want.last,
						$sformatf("got idx %0d x %0d y %0d pos %0d last %0d",
							got.index, got.coord_x, got.coord_y, got.position, got.last));
			end
		endfunction
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [qoig_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0]                  pwdata = '0;
	logic [31:0]                  prdata;
	logic                         pready;

	qoig_req_if req_ch();
	qoig_rsp_if rsp_ch();

	cell_order_book book = new();
	int unsigned    quiet_cycles = 0;

	quadtree_order_index_generator_core #(
		.MAX_SIDE   (SIDE_LIMIT),
		.STACK_DEPTH(STACK_LEVELS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// every channel input known from time zero
	initial begin
		req_ch.valid   = 1'b0;
		req_ch.restart = 1'b0;
		rsp_ch.ready   = 1'b0;
	end

	// response side: check every accepted cell against the oldest prediction
	always @(posedge clk) begin : rsp_monitor
		cell_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.index    = rsp_ch.index;
			got.coord_x  = rsp_ch.coord_x;
			got.coord_y  = rsp_ch.coord_y;
			got.position = rsp_ch.position;
			got.last     = rsp_ch.last;
			book.check_cell(got);
		end
	end

	// watchdog: cycles without any transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL quadtree_order_index_generator_core");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// response ready: random stalls, one calm stretch, one long hold-off
	// in the middle of the big traversal so the block backs up into the request side
	initial begin : rsp_ready_driver
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && book.cells_checked >= 700) begin
				held = 1'b1;
				rsp_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (book.cells_checked >= 450 && book.cells_checked < 650)
				rsp_ch.ready = 1'b1;
			else
				rsp_ch.ready = ($urandom_range(99) >= 25);
		end
	end

	// apb write: setup then access, register lands when pready is seen
	task automatic write_reg(input logic [qoig_pkg::PADDR_W-1:0] addr,
			input logic [31:0] data);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		book.set_reg(addr, data);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// let every owed cell come back, then give the sequencer time to go idle
	task automatic drain();
		while (book.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apply_config(input int unsigned sx, input int unsigned sy,
			input int unsigned st);
		drain();
		write_reg(qoig_pkg::ADDR_SIDE_X, sx);
		write_reg(qoig_pkg::ADDR_SIDE_Y, sy);
		write_reg(qoig_pkg::ADDR_ROW_STRIDE, st);
	endtask

	// one request transaction, entered and left at a falling edge; valid stays up
	task automatic send_request(input logic restart);
		bit calm;
		calm = (book.requests_noted >= 200 && book.requests_noted < 450);
		while (!calm && $urandom_range(99) < 25) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid   = 1'b1;
		req_ch.restart = restart;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		book.note_request(restart);
		@(negedge clk);
	endtask

	// bit i of the pattern is the restart flag of item i
	task automatic send_burst(input int unsigned n, input logic [31:0] pattern);
		for (int i = 0; i < n; i++)
			send_request(pattern[i]);
		req_ch.valid = 1'b0;
	endtask

	task automatic send_random(input int unsigned n, input int unsigned restart_pct);
		for (int i = 0; i < n; i++)
			send_request($urandom_range(99) < restart_pct);
		req_ch.valid = 1'b0;
	endtask

	// side picks lean on tiny grids and the clipped range as well as normal sizes
	function automatic int unsigned random_side();
		case ($urandom_range(9))
			0: return 0;
			1: return $urandom_range(33, 63);
			2, 3: return $urandom_range(1, 4);
			default: return $urandom_range(1, 32);
		endcase
	endfunction

	function automatic int unsigned random_stride();
		case ($urandom_range(7))
			0: return 0;
			1: return 127;
			default: return $urandom_range(0, 127);
		endcase
	endfunction

	initial begin : stimulus
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset grid with restarts at the start and mid-walk
		send_burst(6, 32'b010001);
		// oversized sides clip to the full grid, stride set to its largest value
		apply_config(63, 63, 127);
		send_burst(4, 32'b0);
		// zero sides act as a single cell, every item is last; old position wraps
		apply_config(0, 0, 0);
		send_burst(3, 32'b010);
		// one-wide and one-high strips
		apply_config(1, 32, 64);
		send_burst(3, 32'b0);
		apply_config(32, 1, 1);
		send_burst(3, 32'b100);
		// small odd grid walked past its end
		apply_config(2, 3, 5);
		send_burst(6, 32'b0);

		// one full walk of the largest grid, long enough to pass the last cell
		apply_config($urandom_range(32, 63), $urandom_range(32, 63), $urandom_range(64, 127));
		send_random(1030, 0);

		// random grids with occasional restarts; positions carry across settings
		while (book.requests_noted < ITEM_TARGET) begin
			apply_config(random_side(), random_side(), random_stride());
			send_random($urandom_range(10, 90), 4);
		end

		drain();
		if (book.failures == 0 && book.pending() == 0) begin
			$display("PASS quadtree_order_index_generator_core");
		end else begin
			$display("FAIL quadtree_order_index_generator_core");
		end
		$finish;
	end

endmodule
